/* hdl/adu_pkg.sv */
package adu_pkg;

    localparam logic [31:0] QNAN   = 32'h7FC0_0000;
    localparam logic [31:0] FP_ONE = 32'h3F80_0000;

    localparam logic [31:0] RST_LR    = 32'h3F80_0000;
    localparam logic [31:0] RST_RHO   = 32'h3F73_3333;
    localparam logic [31:0] RST_EPS   = 32'h3586_37BD;
    localparam logic [31:0] RST_SCALE = 32'h3F80_0000;

    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = 26;
    localparam int SQRT_STEPS = 25;

    // front stages plus three rounding stages
    localparam int LAT_MUL  = 4;
    localparam int LAT_ADD  = 5;
    localparam int LAT_DIV  = DIV_STEPS + 4;
    localparam int LAT_SQRT = SQRT_STEPS + 4;

    typedef enum logic [1:0] {
        FP_MUL,
        FP_ADD,
        FP_DIV,
        FP_SQRT
    } t_fpop;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LR,
        CFG_RHO,
        CFG_EPS,
        CFG_SCALE
    } t_cfg_idx;

    // unpacked operand: bit 23 of man has weight 2^ex (ex two's complement)
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [10:0] ex;
        logic [23:0] man;
    } t_unp;

    // unrounded result: bit 49 of man has weight 2^ex
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [10:0] ex;
        logic [49:0] man;
        logic        sticky;
    } t_raw;

    typedef struct packed {
        t_raw       raw;
        logic [5:0] lz;
    } t_rnd1;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [7:0]  expf;
        logic [49:0] man;
        logic        sticky;
    } t_rnd2;

    typedef struct packed {
        t_unp        big;
        t_unp        sml;
        logic [10:0] diff;
        logic        eff_sub;
    } t_addf;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [10:0] ex;
        logic [23:0] mb;
        logic [25:0] rem;
        logic [25:0] q;
    } t_div;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [10:0] ex;
        logic [49:0] x;
        logic [27:0] rem;
        logic [24:0] root;
    } t_sqt;

    function automatic t_unp unpack(input logic [31:0] v);
        t_unp u;
        u.sign = v[31];
        u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
        u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
        u.zero = (v[30:0] == 31'd0);
        u.man  = {v[30:23] != 8'h00, v[22:0]};
        u.ex   = (v[30:23] == 8'h00) ? 11'h782 : ({3'b000, v[30:23]} - 11'd127);
        return u;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd50;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(49 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* hdl/adu_fpop.sv */
module adu_fpop #(
    parameter adu_pkg::t_fpop OP = adu_pkg::FP_MUL
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    adu_pkg::t_raw  w_raw;
    adu_pkg::t_rnd1 r_r1;
    adu_pkg::t_rnd2 r_r2;
    adu_pkg::t_rnd2 n_r2;
    logic [31:0]    n_y;

    if (OP == adu_pkg::FP_MUL) begin : g_mul
        adu_pkg::t_raw r_mf;
        adu_pkg::t_raw n_mf;
        adu_pkg::t_unp ua;
        adu_pkg::t_unp ub;
        logic [47:0]   prod;

        always_comb begin
            ua          = adu_pkg::unpack(i_a);
            ub          = adu_pkg::unpack(i_b);
            prod        = ua.man * ub.man;
            n_mf.nan    = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
            n_mf.inf    = ua.inf | ub.inf;
            n_mf.zero   = ua.zero | ub.zero;
            n_mf.sign   = ua.sign ^ ub.sign;
            n_mf.ex     = ua.ex + ub.ex + 11'd1;
            n_mf.man    = {prod, 2'b00};
            n_mf.sticky = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mf <= n_mf;
            end
        end

        assign w_raw = r_mf;

    end else if (OP == adu_pkg::FP_ADD) begin : g_add
        adu_pkg::t_addf r_a1;
        adu_pkg::t_addf n_a1;
        adu_pkg::t_raw  r_a2;
        adu_pkg::t_raw  n_a2;
        adu_pkg::t_unp  ua;
        adu_pkg::t_unp  ub;
        logic           swap;
        logic [49:0]    a_full;
        logic [49:0]    b_full;
        logic [49:0]    b_sh;
        logic [49:0]    sum;
        logic           st;

        always_comb begin
            ua           = adu_pkg::unpack(i_a);
            ub           = adu_pkg::unpack(i_b);
            swap         = i_a[30:0] < i_b[30:0];
            n_a1.big     = swap ? ub : ua;
            n_a1.sml     = swap ? ua : ub;
            n_a1.diff    = n_a1.big.ex - n_a1.sml.ex;
            n_a1.eff_sub = ua.sign ^ ub.sign;
        end

        // align the smaller operand, fold shifted-out bits into the lsb
        always_comb begin
            a_full = {1'b0, r_a1.big.man, 25'd0};
            b_full = {1'b0, r_a1.sml.man, 25'd0};
            if (r_a1.diff >= 11'd50) begin
                b_sh = 50'd0;
                st   = |r_a1.sml.man;
            end else begin
                b_sh = b_full >> r_a1.diff[5:0];
                st   = |(b_full & ~({50{1'b1}} << r_a1.diff[5:0]));
            end
            b_sh[0]     = b_sh[0] | st;
            sum         = r_a1.eff_sub ? (a_full - b_sh) : (a_full + b_sh);
            n_a2.nan    = r_a1.big.nan | r_a1.sml.nan
                        | (r_a1.big.inf & r_a1.sml.inf & r_a1.eff_sub);
            n_a2.inf    = r_a1.big.inf | r_a1.sml.inf;
            n_a2.zero   = 1'b0;
            n_a2.sign   = (r_a1.eff_sub && sum == 50'd0) ? 1'b0 : r_a1.big.sign;
            n_a2.ex     = r_a1.big.ex + 11'd1;
            n_a2.man    = sum;
            n_a2.sticky = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a1 <= n_a1;
                r_a2 <= n_a2;
            end
        end

        assign w_raw = r_a2;

    end else if (OP == adu_pkg::FP_DIV) begin : g_div
        adu_pkg::t_div r_dv [0:adu_pkg::DIV_STEPS];
        adu_pkg::t_div n_d0;
        adu_pkg::t_unp ua;
        adu_pkg::t_unp ub;
        logic [4:0]    la;
        logic [4:0]    lb;

        always_comb begin
            ua        = adu_pkg::unpack(i_a);
            ub        = adu_pkg::unpack(i_b);
            la        = adu_pkg::lzc24(ua.man);
            lb        = adu_pkg::lzc24(ub.man);
            n_d0.nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
            n_d0.inf  = ua.inf | ub.zero;
            n_d0.zero = ua.zero | ub.inf;
            n_d0.sign = ua.sign ^ ub.sign;
            n_d0.ex   = (ua.ex - {6'd0, la}) - (ub.ex - {6'd0, lb});
            n_d0.mb   = ub.man << lb;
            n_d0.rem  = {2'b00, ua.man << la};
            n_d0.q    = 26'd0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[0] <= n_d0;
            end
        end

        // one restoring quotient bit per stage
        for (genvar k = 1; k <= adu_pkg::DIV_STEPS; k++) begin : g_it
            adu_pkg::t_div n_dv;
            logic [25:0]   diff;
            logic          qb;

            always_comb begin
                n_dv = r_dv[k-1];
                qb   = r_dv[k-1].rem >= {2'b00, r_dv[k-1].mb};
                diff = qb ? (r_dv[k-1].rem - {2'b00, r_dv[k-1].mb}) : r_dv[k-1].rem;
                n_dv.rem = {diff[24:0], 1'b0};
                n_dv.q   = {r_dv[k-1].q[24:0], qb};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[k] <= n_dv;
                end
            end
        end

        always_comb begin
            w_raw.nan    = r_dv[adu_pkg::DIV_STEPS].nan;
            w_raw.inf    = r_dv[adu_pkg::DIV_STEPS].inf;
            w_raw.zero   = r_dv[adu_pkg::DIV_STEPS].zero;
            w_raw.sign   = r_dv[adu_pkg::DIV_STEPS].sign;
            w_raw.ex     = r_dv[adu_pkg::DIV_STEPS].ex;
            w_raw.man    = {r_dv[adu_pkg::DIV_STEPS].q, 24'd0};
            w_raw.sticky = r_dv[adu_pkg::DIV_STEPS].rem != 26'd0;
        end

    end else begin : g_sqrt
        adu_pkg::t_sqt r_sq [0:adu_pkg::SQRT_STEPS];
        adu_pkg::t_sqt n_s0;
        adu_pkg::t_unp ua;
        logic [4:0]    la;
        logic [23:0]   mn;
        logic [10:0]   en;
        logic [10:0]   ee;
        logic [24:0]   m25;

        // even exponent, radicand scaled so the root comes out 25 bits wide
        always_comb begin
            ua        = adu_pkg::unpack(i_a);
            la        = adu_pkg::lzc24(ua.man);
            mn        = ua.man << la;
            en        = ua.ex - {6'd0, la};
            m25       = en[0] ? {mn, 1'b0} : {1'b0, mn};
            ee        = en[0] ? (en - 11'd1) : en;
            n_s0.nan  = ua.nan | (ua.sign & ~ua.zero);
            n_s0.inf  = ua.inf;
            n_s0.zero = ua.zero;
            n_s0.sign = ua.sign;
            n_s0.ex   = {ee[10], ee[10:1]};
            n_s0.x    = {m25, 25'd0};
            n_s0.rem  = 28'd0;
            n_s0.root = 25'd0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[0] <= n_s0;
            end
        end

        for (genvar k = 1; k <= adu_pkg::SQRT_STEPS; k++) begin : g_it
            localparam int I = adu_pkg::SQRT_STEPS - k;
            adu_pkg::t_sqt n_sq;
            logic [27:0]   tmp;
            logic [27:0]   trial;

            always_comb begin
                n_sq  = r_sq[k-1];
                tmp   = {r_sq[k-1].rem[25:0], r_sq[k-1].x[2*I+1:2*I]};
                trial = {1'b0, r_sq[k-1].root, 2'b01};
                if (tmp >= trial) begin
                    n_sq.rem  = tmp - trial;
                    n_sq.root = {r_sq[k-1].root[23:0], 1'b1};
                end else begin
                    n_sq.rem  = tmp;
                    n_sq.root = {r_sq[k-1].root[23:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[k] <= n_sq;
                end
            end
        end

        always_comb begin
            w_raw.nan    = r_sq[adu_pkg::SQRT_STEPS].nan;
            w_raw.inf    = r_sq[adu_pkg::SQRT_STEPS].inf;
            w_raw.zero   = r_sq[adu_pkg::SQRT_STEPS].zero;
            w_raw.sign   = r_sq[adu_pkg::SQRT_STEPS].sign;
            w_raw.ex     = r_sq[adu_pkg::SQRT_STEPS].ex;
            w_raw.man    = {r_sq[adu_pkg::SQRT_STEPS].root, 25'd0};
            w_raw.sticky = r_sq[adu_pkg::SQRT_STEPS].rem != 28'd0;
        end
    end

    // rounding back end: leading zero count, shift, round and pack
    logic signed [10:0] ex_n;
    logic signed [10:0] sh;
    logic signed [10:0] rsh;
    logic               st3;
    logic               up3;
    logic [31:0]        packed_y;

    always_comb begin
        ex_n        = $signed(r_r1.raw.ex) - $signed({5'd0, r_r1.lz});
        sh          = $signed(r_r1.raw.ex) + 11'sd126;
        rsh         = -sh;
        n_r2.nan    = r_r1.raw.nan;
        n_r2.inf    = r_r1.raw.inf;
        n_r2.zero   = r_r1.raw.zero | (r_r1.raw.man == 50'd0);
        n_r2.sign   = r_r1.raw.sign;
        n_r2.sticky = r_r1.raw.sticky;
        if (ex_n >= -11'sd126) begin
            n_r2.man  = r_r1.raw.man << r_r1.lz;
            n_r2.expf = 8'(ex_n + 11'sd127);
            if (ex_n > 11'sd127) begin
                n_r2.inf = 1'b1;
            end
        end else if (!sh[10]) begin
            n_r2.man  = r_r1.raw.man << sh[5:0];
            n_r2.expf = 8'd0;
        end else if (rsh >= 11'sd50) begin
            n_r2.man    = 50'd0;
            n_r2.expf   = 8'd0;
            n_r2.sticky = r_r1.raw.sticky | (r_r1.raw.man != 50'd0);
        end else begin
            n_r2.man    = r_r1.raw.man >> rsh[5:0];
            n_r2.expf   = 8'd0;
            n_r2.sticky = r_r1.raw.sticky
                        | (|(r_r1.raw.man & ~({50{1'b1}} << rsh[5:0])));
        end
    end

    always_comb begin
        st3      = r_r2.sticky | (|r_r2.man[24:0]);
        up3      = r_r2.man[25] & (st3 | r_r2.man[26]);
        // a carry out of the fraction bumps the exponent, up to infinity
        packed_y = {r_r2.sign, r_r2.expf, r_r2.man[48:26]} + {31'd0, up3};
        priority if (r_r2.nan) begin
            n_y = adu_pkg::QNAN;
        end else if (r_r2.inf) begin
            n_y = {r_r2.sign, 8'hFF, 23'd0};
        end else if (r_r2.zero) begin
            n_y = {r_r2.sign, 31'd0};
        end else begin
            n_y = packed_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r1.raw <= w_raw;
            r_r1.lz  <= adu_pkg::lzc50(w_raw.man);
            r_r2     <= n_r2;
            o_y      <= n_y;
        end
    end

endmodule

/* hdl/adadelta_weight_update.sv */
// Throughput: one request per cycle; the depth is set by the longest chain:
// 1 - rho, the new gradient average, one pipelined square root, the
// 26-stage divider and the multiply/add units after it.
// The whole pipe holds while a result waits and m_tready is low.
// Synchronous active-low reset clears the valid bits and restores the config registers.
module adadelta_weight_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // weight_in, gradient_raw, grad_sq_avg_in, upd_sq_avg_in
    input  logic [127:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // weight_out, grad_sq_avg_out, upd_sq_avg_out
    output logic [95:0]                   m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [adu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int P_G    = adu_pkg::LAT_MUL;
    localparam int P_RG   = adu_pkg::LAT_MUL;
    localparam int P_RU   = adu_pkg::LAT_MUL;
    localparam int P_OM   = adu_pkg::LAT_ADD;
    localparam int P_UE   = adu_pkg::LAT_ADD;
    localparam int P_OMG  = P_OM + adu_pkg::LAT_MUL;
    localparam int P_OMGG = P_OMG + adu_pkg::LAT_MUL;
    localparam int P_GN   = P_OMGG + adu_pkg::LAT_ADD;
    localparam int P_NUM  = P_UE + adu_pkg::LAT_SQRT;
    localparam int P_GE   = P_GN + adu_pkg::LAT_ADD;
    localparam int P_DEN  = P_GE + adu_pkg::LAT_SQRT;
    localparam int P_Q    = P_DEN + adu_pkg::LAT_DIV;
    localparam int P_U    = P_Q + adu_pkg::LAT_MUL;
    localparam int P_OMU  = P_U + adu_pkg::LAT_MUL;
    localparam int P_OMUU = P_OMU + adu_pkg::LAT_MUL;
    localparam int P_UN   = P_OMUU + adu_pkg::LAT_ADD;
    localparam int P_AU   = P_U + adu_pkg::LAT_MUL;
    localparam int P_WN   = P_AU + adu_pkg::LAT_ADD;
    localparam int P_OUT  = P_UN;

    logic [31:0] r_lr;
    logic [31:0] r_rho;
    logic [31:0] r_eps;
    logic [31:0] r_scale;

    logic        w_en;
    logic [1:P_OUT] r_vld;

    logic [31:0] w_win;
    logic [31:0] w_graw;
    logic [31:0] w_gin;
    logic [31:0] w_uin;

    logic [31:0] w_g, w_om, w_rg, w_ru, w_ue, w_omg, w_omgg, w_gn, w_num;
    logic [31:0] w_ge, w_den, w_q, w_u, w_omu, w_omuu, w_un, w_au, w_wn;

    logic [31:0] r_g_d   [P_G+1:P_Q];
    logic [31:0] r_om_d  [P_OM+1:P_U];
    logic [31:0] r_rg_d  [P_RG+1:P_OMGG];
    logic [31:0] r_ru_d  [P_RU+1:P_OMUU];
    logic [31:0] r_gn_d  [P_GN+1:P_OUT];
    logic [31:0] r_num_d [P_NUM+1:P_DEN];
    logic [31:0] r_u_d   [P_U+1:P_OMU];
    logic [31:0] r_w_d   [1:P_AU];
    logic [31:0] r_wn_d  [P_WN+1:P_OUT];

    assign w_win  = s_tdata[31:0];
    assign w_graw = s_tdata[63:32];
    assign w_gin  = s_tdata[95:64];
    assign w_uin  = s_tdata[127:96];

    // the pipe moves as one; it holds only when the output stage is full and m_tready is low
    assign w_en        = !r_vld[P_OUT] || m_tready;
    assign s_tready    = w_en;
    assign m_tvalid    = r_vld[P_OUT];
    assign m_tdata     = {w_un, r_gn_d[P_OUT], r_wn_d[P_OUT]};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= adu_pkg::RST_LR;
            r_rho   <= adu_pkg::RST_RHO;
            r_eps   <= adu_pkg::RST_EPS;
            r_scale <= adu_pkg::RST_SCALE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adu_pkg::CFG_LR:    r_lr    <= i_cfg_data;
                adu_pkg::CFG_RHO:   r_rho   <= i_cfg_data;
                adu_pkg::CFG_EPS:   r_eps   <= i_cfg_data;
                adu_pkg::CFG_SCALE: r_scale <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {s_tvalid, r_vld[1:P_OUT-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_d[P_G+1]     <= w_g;
            r_om_d[P_OM+1]   <= w_om;
            r_rg_d[P_RG+1]   <= w_rg;
            r_ru_d[P_RU+1]   <= w_ru;
            r_gn_d[P_GN+1]   <= w_gn;
            r_num_d[P_NUM+1] <= w_num;
            r_u_d[P_U+1]     <= w_u;
            r_w_d[1]         <= w_win;
            r_wn_d[P_WN+1]   <= w_wn;
            for (int k = P_G + 2; k <= P_Q; k++) r_g_d[k] <= r_g_d[k-1];
            for (int k = P_OM + 2; k <= P_U; k++) r_om_d[k] <= r_om_d[k-1];
            for (int k = P_RG + 2; k <= P_OMGG; k++) r_rg_d[k] <= r_rg_d[k-1];
            for (int k = P_RU + 2; k <= P_OMUU; k++) r_ru_d[k] <= r_ru_d[k-1];
            for (int k = P_GN + 2; k <= P_OUT; k++) r_gn_d[k] <= r_gn_d[k-1];
            for (int k = P_NUM + 2; k <= P_DEN; k++) r_num_d[k] <= r_num_d[k-1];
            for (int k = P_U + 2; k <= P_OMU; k++) r_u_d[k] <= r_u_d[k-1];
            for (int k = 2; k <= P_AU; k++) r_w_d[k] <= r_w_d[k-1];
            for (int k = P_WN + 2; k <= P_OUT; k++) r_wn_d[k] <= r_wn_d[k-1];
        end
    end

    // g = graw * scale, om = 1 - rho
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_g (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_graw), .i_b(r_scale), .o_y(w_g));
    adu_fpop #(.OP(adu_pkg::FP_ADD)) u_om (
        .i_clk(i_clk), .i_en(w_en), .i_a(adu_pkg::FP_ONE),
        .i_b({~r_rho[31], r_rho[30:0]}), .o_y(w_om));

    // new squared-gradient average
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_rg (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_rho), .i_b(w_gin), .o_y(w_rg));
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_omg (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_om), .i_b(r_g_d[P_OM]), .o_y(w_omg));
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_omgg (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_omg), .i_b(r_g_d[P_OMG]), .o_y(w_omgg));
    adu_fpop #(.OP(adu_pkg::FP_ADD)) u_gn (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_rg_d[P_OMGG]), .i_b(w_omgg), .o_y(w_gn));

    // update = sqrt(U + eps) / sqrt(G + eps) * g
    adu_fpop #(.OP(adu_pkg::FP_ADD)) u_ue (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_uin), .i_b(r_eps), .o_y(w_ue));
    adu_fpop #(.OP(adu_pkg::FP_SQRT)) u_num (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_ue), .i_b(r_eps), .o_y(w_num));
    adu_fpop #(.OP(adu_pkg::FP_ADD)) u_ge (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_gn), .i_b(r_eps), .o_y(w_ge));
    adu_fpop #(.OP(adu_pkg::FP_SQRT)) u_den (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_ge), .i_b(r_eps), .o_y(w_den));
    adu_fpop #(.OP(adu_pkg::FP_DIV)) u_q (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_num_d[P_DEN]), .i_b(w_den), .o_y(w_q));
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_u (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_q), .i_b(r_g_d[P_Q]), .o_y(w_u));

    // new squared-update average
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_ru (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_rho), .i_b(w_uin), .o_y(w_ru));
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_omu (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_om_d[P_U]), .i_b(w_u), .o_y(w_omu));
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_omuu (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_omu), .i_b(r_u_d[P_OMU]), .o_y(w_omuu));
    adu_fpop #(.OP(adu_pkg::FP_ADD)) u_un (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ru_d[P_OMUU]), .i_b(w_omuu), .o_y(w_un));

    // w - alpha * update
    adu_fpop #(.OP(adu_pkg::FP_MUL)) u_au (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_lr), .i_b(w_u), .o_y(w_au));
    adu_fpop #(.OP(adu_pkg::FP_ADD)) u_wn (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_w_d[P_AU]),
        .i_b({~w_au[31], w_au[30:0]}), .o_y(w_wn));

endmodule

/* tb/adadelta_weight_update_test.sv */
module adadelta_weight_update_test;

    localparam int RAND_ITEMS = 1350;
    localparam int DRAIN      = 130;
    localparam int LIMIT      = 600000;

    typedef struct packed {
        logic [31:0] weight;
        logic [31:0] grad;
        logic [31:0] gsq;
        logic [31:0] usq;
    } t_req;

    typedef struct packed {
        logic [31:0] weight;
        logic [31:0] gsq;
        logic [31:0] usq;
    } t_res;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [127:0]                  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [95:0]                   m_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [adu_pkg::CFG_IDX_W-1:0] i_cfg_index = adu_pkg::CFG_LR;
    logic [31:0]                   i_cfg_data = '0;

    adadelta_weight_update dut (.*);

    always #4 i_clk = ~i_clk;

    // model copy of the registers
    logic [31:0] alpha = adu_pkg::RST_LR;
    logic [31:0] rho   = adu_pkg::RST_RHO;
    logic [31:0] eps   = adu_pkg::RST_EPS;
    logic [31:0] scale = adu_pkg::RST_SCALE;

    t_req pend_reqs[$];
    t_res expected_res[$];
    int   mismatches = 0;
    int   cycles = 0;

    // ---------------- FP32 arithmetic, exact via double + single rounding ----
    function automatic logic is_nan(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] != 0;
    endfunction
    function automatic logic is_inf(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] == 0;
    endfunction
    function automatic logic is_zero(input logic [31:0] b);
        return b[30:0] == 0;
    endfunction

    function automatic real mag_of(input logic [31:0] b);
        int ex;
        ex = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
        return real'({b[30:23] != 0, b[22:0]}) * (2.0 ** ex);
    endfunction

    function automatic real real_of(input logic [31:0] b);
        return b[31] ? -mag_of(b) : mag_of(b);
    endfunction

    // round a nonnegative double magnitude to single, nearest even
    function automatic logic [31:0] round_single(input logic s, input real r);
        logic [63:0] rb, m, q, rem, half, res;
        int e, sh;
        if (r == 0.0) return {s, 31'd0};
        rb = $realtobits(r);
        e = int'(rb[62:52]) - 1023;
        m = {11'd0, 1'b1, rb[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 63) sh = 63;
        q = m >> sh;
        rem = m - (q << sh);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        if (e >= -126) res = (64'(e + 126) << 23) + q;
        else res = q;
        if (res >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
        return {s, res[30:0]};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return adu_pkg::QNAN;
        if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return adu_pkg::QNAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        return round_single(s, mag_of(a) * mag_of(b));
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        real r;
        if (is_nan(a) || is_nan(b)) return adu_pkg::QNAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return adu_pkg::QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        r = real_of(a) + real_of(b);
        if (r == 0.0) return {is_zero(a) && is_zero(b) && a[31] && b[31], 31'd0};
        return round_single(r < 0.0, r < 0.0 ? -r : r);
    endfunction

    function automatic logic [31:0] fdiv(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return adu_pkg::QNAN;
        if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b))) return adu_pkg::QNAN;
        if (is_inf(a) || is_zero(b)) return {s, 8'hFF, 23'd0};
        if (is_inf(b) || is_zero(a)) return {s, 31'd0};
        return round_single(s, mag_of(a) / mag_of(b));
    endfunction

    function automatic logic [31:0] fsqrt(input logic [31:0] a);
        if (is_nan(a)) return adu_pkg::QNAN;
        if (is_zero(a)) return a;
        if (a[31]) return adu_pkg::QNAN;
        if (is_inf(a)) return a;
        return round_single(1'b0, $sqrt(mag_of(a)));
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] b);
        return is_nan(b) ? adu_pkg::QNAN : b;
    endfunction

    function automatic t_res adadelta_step(input t_req q);
        logic [31:0] g, om, gn, num, den, u, un, au, wn;
        t_res r;
        g  = fmul(q.grad, scale);
        om = fadd(adu_pkg::FP_ONE, {~rho[31], rho[30:0]});
        gn = fadd(fmul(rho, q.gsq), fmul(fmul(om, g), g));
        num = fsqrt(fadd(q.usq, eps));
        den = fsqrt(fadd(gn, eps));
        u  = fmul(fdiv(num, den), g);
        un = fadd(fmul(rho, q.usq), fmul(fmul(om, u), u));
        au = fmul(alpha, u);
        wn = fadd(q.weight, {~au[31], au[30:0]});
        r.weight = canon(wn);
        r.gsq    = canon(gn);
        r.usq    = canon(un);
        return r;
    endfunction

    // ---------------- request driver ----------------
    t_req cur_req;
    int   gap_left = 0;
    int   send_cnt = 0;
    logic send_burst = 1'b0;

    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_res.push_back(adadelta_step(cur_req));
            if (!(s_tvalid && !s_tready)) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_reqs.size() > 0) begin
                    cur_req = pend_reqs.pop_front();
                    nv = 1'b1;
                    send_cnt++;
                    if (send_cnt % 40 == 0) send_burst = $urandom_range(0, 2) == 0;
                    gap_left = send_burst ? 0 : $urandom_range(0, 17);
                    s_tdata <= {cur_req.usq, cur_req.gsq, cur_req.grad, cur_req.weight};
                end
                s_tvalid <= nv;
            end
        end
    end

    // ---------------- result monitor ----------------
    int   stall_left = 0;
    int   recv_cnt = 0;
    logic recv_burst = 1'b0;

    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = t_res'({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]});
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    exp_r = expected_res.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch w %h/%h gsq %h/%h usq %h/%h (exp/got)",
                                     exp_r.weight, got.weight, exp_r.gsq, got.gsq,
                                     exp_r.usq, got.usq);
                    end
                end
                recv_cnt++;
                if (recv_cnt % 50 == 0) recv_burst = $urandom_range(0, 2) == 0;
                stall_left = recv_burst ? 0 : $urandom_range(0, 17);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic reg_write(input adu_pkg::t_cfg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            adu_pkg::CFG_LR:    alpha = v;
            adu_pkg::CFG_RHO:   rho   = v;
            adu_pkg::CFG_EPS:   eps   = v;
            adu_pkg::CFG_SCALE: scale = v;
        endcase
    endtask

    // all requests sent and all results seen, then let the pipe settle
    task automatic wait_idle();
        while (!(pend_reqs.size() == 0 && !s_tvalid && expected_res.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_fp(input int lo, input int hi, input logic pos);
        logic [31:0] specials[10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                      32'h7FC0_0000, 32'hFF80_0001, 32'h0000_0001,
                                      32'h807F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000};
        int k;
        k = $urandom_range(0, 99);
        if (k < 8) return specials[$urandom_range(0, 9)];
        if (k < 30) return $urandom;
        return {pos ? 1'b0 : 1'($urandom), 8'($urandom_range(lo, hi)), 23'($urandom)};
    endfunction

    task automatic run_phase(input logic [31:0] a, input logic [31:0] r,
                             input logic [31:0] e, input logic [31:0] s, input int n);
        t_req q;
        reg_write(adu_pkg::CFG_LR, a);
        reg_write(adu_pkg::CFG_RHO, r);
        reg_write(adu_pkg::CFG_EPS, e);
        reg_write(adu_pkg::CFG_SCALE, s);
        for (int i = 0; i < n; i++) begin
            q.weight = pick_fp(100, 140, 1'b0);
            q.grad   = pick_fp(100, 135, 1'b0);
            q.gsq    = pick_fp(90, 135, 1'b1);
            q.usq    = pick_fp(90, 135, 1'b1);
            pend_reqs.push_back(q);
        end
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at reset settings
        pend_reqs.push_back('{32'h3F80_0000, 32'h3DCC_CCCD, 32'h3C23_D70A, 32'h3A83_126F});
        pend_reqs.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
        pend_reqs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pend_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pend_reqs.push_back('{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF});
        pend_reqs.push_back('{32'h7F80_0000, 32'h3F80_0000, 32'h0, 32'h0});
        pend_reqs.push_back('{32'h4000_0000, 32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000});
        pend_reqs.push_back('{32'h4000_0000, 32'hFF80_0000, 32'h7F80_0000, 32'h7F80_0000});
        pend_reqs.push_back('{32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
        pend_reqs.push_back('{32'h3F80_0000, 32'hFFC1_2345, 32'h3F80_0000, 32'h3F80_0000});
        // negative averages: square root of a negative number
        pend_reqs.push_back('{32'h3F80_0000, 32'h3F80_0000, 32'hC000_0000, 32'h3F80_0000});
        pend_reqs.push_back('{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hC000_0000});
        // subnormals
        pend_reqs.push_back('{32'h0000_0001, 32'h807F_FFFF, 32'h0000_0003, 32'h0040_0000});
        pend_reqs.push_back('{32'h8000_0001, 32'h0000_0001, 32'h007F_FFFF, 32'h0000_0001});
        pend_reqs.push_back('{32'hC2C8_0000, 32'h5F00_0000, 32'h0, 32'h0});
        wait_idle();

        run_phase(adu_pkg::RST_LR, adu_pkg::RST_RHO, adu_pkg::RST_EPS,
                  adu_pkg::RST_SCALE, 300);
        // extremes: zero rate, rho at zero, zero epsilon
        run_phase(32'h0, 32'h0, 32'h0, 32'h3A80_0000, 160);
        // rho just under one, negative rate, tiny subnormal epsilon, big scale
        run_phase(32'hBC23_D70A, 32'h3F7F_FFFF, 32'h0000_0001, 32'h4B80_0000, 160);
        // odd registers: rho one, infinite rate, huge epsilon, max scale
        run_phase(32'h7F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 120);
        // NaN rate and rho, negative epsilon and scale
        run_phase(32'hFFC0_0001, 32'h7FC0_0000, 32'hB586_37BD, 32'hBF80_0000, 120);
        run_phase(32'h3A83_126F, 32'h3F66_6666, 32'h322B_CC77, 32'h3800_0000,
                  RAND_ITEMS - 860);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
